/* hw/rtl/number_to_radix_digit_string_macros.svh */
// Assertion macros shared by the radix text converter RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef NUMBER_TO_RADIX_DIGIT_STRING_MACROS_SVH
`define NUMBER_TO_RADIX_DIGIT_STRING_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NTR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ntr_pkg.sv */
// Package for the radix text converter: widths, character codes, beat and
// control types, and the digit-to-ASCII function. Depends on nothing.
`timescale 1ns / 1ps

package ntr_pkg;

  localparam int NUMBER_W    = 64;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 6;
  localparam int RADIX_W     = 6;
  localparam int LIMIT_W     = 5;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int DIV_STEP    = 8;   // quotient bits resolved per divide cycle

  localparam int INT_BITS_DEF        = 32;
  localparam int FRAC_BITS_DEF       = 32;
  localparam int MAX_FRAC_DIGITS_DEF = 29;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd6;

  localparam logic [DIGIT_W-1:0] DIGIT_DEC_MAX = 6'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX     = 6'd35;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIX      = 1'b0,
    REG_FRAC_LIMIT = 1'b1
  } ntr_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DCHECK,
    ST_FRAC,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC_OUT
  } ntr_state_t;

  typedef enum logic [1:0] {
    ISSUE_SIGN,
    ISSUE_INT,
    ISSUE_DOT,
    ISSUE_FRAC
  } ntr_issue_t;

  typedef struct packed {
    logic signed [NUMBER_W-1:0] number_value;
  } number_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } char_beat_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       frac_step;
    logic       emit_init;
    logic       issue;
    ntr_issue_t issue_kind;
  } ntr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic q_zero;
    logic frac_more;
    logic issue_ok;
    logic neg;
    logic int_last;
    logic has_frac;
    logic frac_last;
  } ntr_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dc;
    dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (dc <= DIGIT_DEC_MAX) begin
      return CHAR_ZERO + CHAR_W'(dc);
    end else begin
      return CHAR_A + CHAR_W'(dc - DIGIT_TEN);
    end
  endfunction

endpackage

/* hw/rtl/ntr_stream_if.sv */
// Valid/ready stream interface used for the number and character channels.
// Payload type is a parameter; the beat types live in ntr_pkg.
`timescale 1ns / 1ps

interface ntr_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/ntr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module ntr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hw/rtl/ntr_ctrl.sv */
// Sequencer for the radix text converter: accepts a number, steps the
// datapath through digit generation and character issue. Uses ntr_pkg.
`timescale 1ns / 1ps
`include "number_to_radix_digit_string_macros.svh"

module ntr_ctrl
  import ntr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ntr_stat_t stat,
  output ntr_cmd_t  cmd
);
  ntr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.issue_kind = ISSUE_SIGN;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_DCHECK;
        end
      end
      ST_DCHECK: begin
        state_next = stat.q_zero ? ST_FRAC : ST_DIVIDE;
      end
      ST_FRAC: begin
        if (stat.frac_more) begin
          cmd.frac_step = 1'b1;
        end else begin
          cmd.emit_init = 1'b1;
          state_next    = stat.neg ? ST_SIGN : ST_INT;
        end
      end
      ST_SIGN: begin
        if (stat.issue_ok) begin
          cmd.issue  = 1'b1;
          state_next = ST_INT;
        end
      end
      ST_INT: begin
        cmd.issue_kind = ISSUE_INT;
        if (stat.issue_ok) begin
          cmd.issue = 1'b1;
          if (stat.int_last) begin
            state_next = stat.has_frac ? ST_DOT : ST_IDLE;
          end
        end
      end
      ST_DOT: begin
        cmd.issue_kind = ISSUE_DOT;
        if (stat.issue_ok) begin
          cmd.issue  = 1'b1;
          state_next = ST_FRAC_OUT;
        end
      end
      ST_FRAC_OUT: begin
        cmd.issue_kind = ISSUE_FRAC;
        if (stat.issue_ok) begin
          cmd.issue = 1'b1;
          if (stat.frac_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `NTR_ASSERT_NOW(a_issue_room, clk, rst, cmd.issue, stat.issue_ok, "issue without output room")
  `NTR_ASSERT_NEXT(a_load_divides, clk, rst, cmd.load, state == ST_DIVIDE, "load skipped divide")
  `NTR_ASSERT_NOW(a_ready_idle, clk, rst, in_ready, state == ST_IDLE, "input ready outside idle")
endmodule

/* hw/rtl/ntr_datapath.sv */
// Datapath for the radix text converter: magnitude split, radix divider,
// fraction multiplier, digit RAM and output register. Uses ntr_pkg, ntr_ram.
`timescale 1ns / 1ps
`include "number_to_radix_digit_string_macros.svh"

module ntr_datapath
  import ntr_pkg::*;
#(
  parameter int INT_BITS        = INT_BITS_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [NUMBER_W-1:0] number_value,
  input  logic [RADIX_W-1:0]         radix,
  input  logic [LIMIT_W-1:0]         fraction_digit_limit,
  input  ntr_cmd_t                   cmd,
  output ntr_stat_t                  stat,
  ntr_stream_if.source               chars
);
  localparam int TW      = INT_BITS + FRAC_BITS;
  localparam int DIV_CYC = (INT_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int QW      = DIV_CYC * DIV_STEP;
  localparam int DCW     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int ICW     = $clog2(INT_BITS + 1);
  localparam int FCW     = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int MAXD    = (INT_BITS > MAX_FRAC_DIGITS) ? INT_BITS : MAX_FRAC_DIGITS;
  localparam int EW      = $clog2(MAXD);
  localparam int CW      = EW + FCW;
  localparam int DEPTH   = INT_BITS + MAX_FRAC_DIGITS;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = FRAC_BITS + RADIX_W;
  localparam logic [AW-1:0] FRAC_BASE = AW'(INT_BITS);

  // number split
  logic [TW-1:0] x_bits;
  logic [TW-1:0] mag;
  logic          x_neg;

  // registers
  logic                 neg;
  logic [RADIX_W-1:0]   r_eff;
  logic [FCW-1:0]       lim_eff;
  logic [QW-1:0]        qsh;
  logic [DIGIT_W-1:0]   rem;
  logic [DCW-1:0]       dcnt;
  logic [ICW-1:0]       int_cnt;
  logic [FRAC_BITS-1:0] fr;
  logic [FCW-1:0]       frac_cnt;
  logic [FCW-1:0]       frac_keep;
  logic [EW-1:0]        emit_idx;
  logic                 pend;
  logic                 pend_lit;
  logic [CHAR_W-1:0]    pend_char;
  logic                 pend_last;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;

  // divide step
  logic [DIGIT_W-1:0]  rem_w;
  logic [DIGIT_W:0]    trial;
  logic [DIV_STEP-1:0] qb;
  logic [QW-1:0]       qsh_next;
  logic                div_last;

  // fraction step
  logic [PW-1:0]      prod;
  logic [DIGIT_W-1:0] frac_digit;

  // digit RAM
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DIGIT_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  logic issue_last;
  logic int_last;
  logic frac_last;
  logic int_issue;

  assign x_bits = TW'(number_value);
  assign x_neg  = x_bits[TW-1];
  assign mag    = x_neg ? (TW'(0) - x_bits) : x_bits;

  // Restoring division by the radix, DIV_STEP quotient bits per cycle.
  always_comb begin
    rem_w = (dcnt == '0) ? '0 : rem;
    qb    = '0;
    trial = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial = {rem_w, qsh[QW-1-k]};
      if (trial >= {1'b0, r_eff}) begin
        trial            = trial - {1'b0, r_eff};
        qb[DIV_STEP-1-k] = 1'b1;
      end
      rem_w = trial[DIGIT_W-1:0];
    end
    qsh_next = (qsh << DIV_STEP) | QW'(qb);
  end

  assign div_last   = (dcnt == DCW'(DIV_CYC - 1));
  assign prod       = PW'(fr) * PW'(r_eff);
  assign frac_digit = prod[PW-1:FRAC_BITS];

  assign int_last  = (emit_idx == '0);
  assign frac_last = (CW'(emit_idx) + CW'(1) == CW'(frac_keep));
  assign int_issue = cmd.issue && (cmd.issue_kind == ISSUE_INT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= x_neg;
      if (radix < RADIX_MIN) begin
        r_eff <= RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
        r_eff <= RADIX_MAX;
      end else begin
        r_eff <= radix;
      end
      lim_eff   <= (fraction_digit_limit > LIMIT_W'(MAX_FRAC_DIGITS)) ?
                   FCW'(MAX_FRAC_DIGITS) : FCW'(fraction_digit_limit);
      qsh       <= QW'(mag[TW-1:FRAC_BITS]);
      fr        <= mag[FRAC_BITS-1:0];
      dcnt      <= '0;
      int_cnt   <= '0;
      frac_cnt  <= '0;
      frac_keep <= '0;
    end
    if (cmd.div_step) begin
      qsh  <= qsh_next;
      rem  <= rem_w;
      dcnt <= div_last ? '0 : dcnt + DCW'(1);
      if (div_last) begin
        int_cnt <= int_cnt + ICW'(1);
      end
    end
    if (cmd.frac_step) begin
      fr       <= prod[FRAC_BITS-1:0];
      frac_cnt <= frac_cnt + FCW'(1);
      if (frac_digit != '0) begin
        frac_keep <= frac_cnt + FCW'(1);
      end
    end
    if (cmd.emit_init) begin
      emit_idx <= EW'(int_cnt - ICW'(1));
    end
    if (cmd.issue) begin
      unique case (cmd.issue_kind) inside
        ISSUE_INT:  emit_idx <= emit_idx - EW'(1);
        ISSUE_DOT:  emit_idx <= '0;
        ISSUE_FRAC: emit_idx <= emit_idx + EW'(1);
        default:    emit_idx <= emit_idx;
      endcase
    end
  end

  // Digit RAM: integer digits from address 0 (least significant first),
  // fraction digits from FRAC_BASE.
  assign ram_we    = (cmd.div_step && div_last) || cmd.frac_step;
  assign ram_waddr = cmd.frac_step ? (FRAC_BASE + AW'(frac_cnt)) : AW'(int_cnt);
  assign ram_wdata = cmd.frac_step ? frac_digit : rem_w;
  assign ram_re    = cmd.issue &&
                     (cmd.issue_kind == ISSUE_INT || cmd.issue_kind == ISSUE_FRAC);
  assign ram_raddr = (cmd.issue_kind == ISSUE_FRAC) ? (FRAC_BASE + AW'(emit_idx))
                                                   : AW'(emit_idx);

  ntr_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DEPTH)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (cmd.issue_kind) inside
      ISSUE_SIGN, ISSUE_DOT: issue_last = 1'b0;
      ISSUE_INT:             issue_last = int_last && (frac_keep == '0);
      ISSUE_FRAC:            issue_last = frac_last;
      default:               issue_last = 1'b0;
    endcase
  end

  // Issue stage: the registered RAM read, then the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.issue;
      if (pend) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (cmd.issue) begin
      pend_lit  <= (cmd.issue_kind == ISSUE_SIGN || cmd.issue_kind == ISSUE_DOT);
      pend_char <= (cmd.issue_kind == ISSUE_SIGN) ? CHAR_MINUS : CHAR_DOT;
      pend_last <= issue_last;
    end
    if (pend) begin
      out_char <= pend_lit ? pend_char : digit_char(ram_rdata);
      out_last <= pend_last;
    end
  end

  assign chars.valid          = out_valid;
  assign chars.data.text_char = out_char;
  assign chars.data.last_char = out_last;

  assign stat.div_last  = div_last;
  assign stat.q_zero    = (qsh == '0);
  assign stat.frac_more = (frac_cnt < lim_eff) && (fr != '0);
  assign stat.issue_ok  = !pend && (!out_valid || chars.ready);
  assign stat.neg       = neg;
  assign stat.int_last  = int_last;
  assign stat.has_frac  = (frac_keep != '0);
  assign stat.frac_last = frac_last;

  `NTR_ASSERT_NOW(a_pend_room, clk, rst, pend, !out_valid, "read data arrived at a full output")
  `NTR_ASSERT_NOW(a_keep_le_cnt, clk, rst, cmd.frac_step, frac_keep <= frac_cnt, "keep count too large")
  `NTR_ASSERT_NOW(a_int_index, clk, rst, int_issue, emit_idx < int_cnt, "integer read past count")
endmodule

/* hw/rtl/number_to_radix_digit_string.sv */
// Fixed-point (Q INT_BITS.FRAC_BITS) to ASCII text in radix 2..36, one character per beat.
// Digits come from the 8-bit-per-cycle radix divider and the one-digit-per-cycle fraction
// multiplier; each character then passes the registered digit RAM read and the output
// register, and a character is issued only with no read pending and the output free or draining.
// One number at a time; the next is accepted once its last character is issued.
// Synchronous active-high rst: radix 10, fraction limit 6, no beat pending.
`timescale 1ns / 1ps

module number_to_radix_digit_string
  import ntr_pkg::*;
#(
  parameter int INT_BITS        = INT_BITS_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  ntr_stream_if.sink             numbers,
  ntr_stream_if.source           chars
);
  // Configuration registers: the user writes them only while the block is quiet; the block does not enforce it.
  logic [RADIX_W-1:0] radix;
  logic [LIMIT_W-1:0] fraction_digit_limit;

  ntr_cmd_t  cmd;
  ntr_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix                <= RADIX_RESET;
      fraction_digit_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (ntr_reg_t'(wr_index))
        REG_RADIX:      radix                <= wr_data[RADIX_W-1:0];
        REG_FRAC_LIMIT: fraction_digit_limit <= wr_data[LIMIT_W-1:0];
        default:        radix                <= radix;
      endcase
    end
  end

  // Sequencer: owns the input handshake and drives the datapath commands.
  ntr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (numbers.valid),
    .in_ready (numbers.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: divider, multiplier, digit store and the output beat register.
  ntr_datapath #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .number_value         (numbers.data.number_value),
    .radix                (radix),
    .fraction_digit_limit (fraction_digit_limit),
    .cmd                  (cmd),
    .stat                 (stat),
    .chars                (chars)
  );
endmodule

/* bench/tb_number_to_radix_digit_string.sv */
// Self-checking bench for number_to_radix_digit_string: Q32.32 numbers go in, radix text
// comes out one character per beat and is compared against a predictor kept in a small class.
// Depends on ntr_pkg and ntr_stream_if from the RTL.
`timescale 1ns / 1ps

module tb_number_to_radix_digit_string;
  import ntr_pkg::*;

  // Predicts the character text of every accepted number and checks each character beat
  // against the oldest prediction still waiting.
  class radix_text_scoreboard;
    logic [RADIX_W-1:0] radix_reg;
    logic [LIMIT_W-1:0] limit_reg;
    char_beat_t         pending_text[$];
    int                 errors;
    int                 numbers_seen;
    int                 chars_seen;

    function new();
      radix_reg    = RADIX_RESET;
      limit_reg    = LIMIT_RESET;
      errors       = 0;
      numbers_seen = 0;
      chars_seen   = 0;
    endfunction

    function void write_reg(ntr_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_RADIX:      radix_reg = val[RADIX_W-1:0];
        REG_FRAC_LIMIT: limit_reg = val[LIMIT_W-1:0];
        default:        ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] glyph(int unsigned d);
      if (d < 10) return CHAR_ZERO + CHAR_W'(d);
      return CHAR_A + CHAR_W'(d - 10);
    endfunction

    function void push_char(logic [CHAR_W-1:0] c);
      char_beat_t b;
      b.text_char = c;
      b.last_char = 1'b0;
      pending_text = {pending_text, b};
    endfunction

    function void add_number(logic [NUMBER_W-1:0] v);
      logic              neg;
      logic [63:0]       mag;
      logic [31:0]       ipart;
      logic [31:0]       fpart;
      logic [63:0]       prod;
      int unsigned       base;
      int unsigned       lim;
      int unsigned       int_digits[32];
      int unsigned       frac_digits[29];
      int                n_int;
      int                n_frac;
      int                i;
      neg   = v[63];
      mag   = neg ? (~v + 64'd1) : v;
      ipart = mag[63:32];
      fpart = mag[31:0];
      base  = radix_reg;
      if (base < 2) base = 2;
      if (base > 36) base = 36;
      lim = limit_reg;
      if (lim > MAX_FRAC_DIGITS_DEF) lim = MAX_FRAC_DIGITS_DEF;

      // Integer digits, least significant first; a zero part still yields one digit.
      n_int = 0;
      do begin
        int_digits[n_int] = ipart % base;
        ipart = ipart / base;
        n_int++;
      end while (ipart != 0);

      // Fraction digits by exact multiply-by-radix, then drop trailing zeros.
      n_frac = 0;
      while (n_frac < int'(lim) && fpart != 0) begin
        prod = {32'd0, fpart} * 64'(base);
        frac_digits[n_frac] = prod[63:32];
        fpart = prod[31:0];
        n_frac++;
      end
      while (n_frac > 0 && frac_digits[n_frac-1] == 0) n_frac--;

      if (neg) push_char(CHAR_MINUS);
      for (i = n_int - 1; i >= 0; i--) push_char(glyph(int_digits[i]));
      if (n_frac > 0) begin
        push_char(CHAR_DOT);
        for (i = 0; i < n_frac; i++) push_char(glyph(frac_digits[i]));
      end
      pending_text[pending_text.size()-1].last_char = 1'b1;
      numbers_seen++;
    endfunction

    function void check_char(char_beat_t got);
      char_beat_t want;
      chars_seen++;
      if (pending_text.size() == 0) begin
        errors++;
        $display("%0t: unexpected character %h last %b with nothing pending",
                 $time, got.text_char, got.last_char);
        return;
      end
      want = pending_text.pop_front();
      if (got.text_char !== want.text_char) begin
        errors++;
        $display("%0t: text_char expected %h '%c' actual %h '%c'", $time,
                 want.text_char, want.text_char, got.text_char, got.text_char);
      end
      if (got.last_char !== want.last_char) begin
        errors++;
        $display("%0t: last_char expected %b actual %b", $time,
                 want.last_char, got.last_char);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  ntr_stream_if #(.data_t(number_beat_t)) number_bus ();
  ntr_stream_if #(.data_t(char_beat_t))   char_bus ();

  number_to_radix_digit_string dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .numbers  (number_bus),
    .chars    (char_bus)
  );

  radix_text_scoreboard sb;

  // Largest idle gap each side may draw per beat; zero gives back-to-back stretches.
  int send_gap_max;
  int recv_gap_max;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run: every number at 63 characters, each beat
  // held by the largest sink stall, plus the digit work for every number.
  initial begin
    #25_000_000;
    $display("number_to_radix_digit_string regression: fail");
    $finish;
  end

  // Character sink: draw a stall per beat, hold ready low for it, then take one beat.
  initial begin
    char_bus.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      int stall;
      stall = $urandom_range(0, recv_gap_max);
      @(negedge clk);
      if (stall > 0) begin
        char_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      char_bus.ready <= 1'b1;
      do @(posedge clk); while (char_bus.valid !== 1'b1);
      sb.check_char(char_bus.data);
    end
  end

  // Present one number after a random gap and hold it until the block takes the beat.
  // A zero gap keeps valid high straight into the next beat.
  task automatic send_number(input logic [NUMBER_W-1:0] value);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      number_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    number_bus.valid             <= 1'b1;
    number_bus.data.number_value <= value;
    do @(posedge clk); while (number_bus.ready !== 1'b1);
    sb.add_number(value);
  endtask

  // Drop valid and hold off until every predicted character has arrived, then let the
  // block finish its last issue before anything else happens.
  task automatic drain();
    @(negedge clk);
    number_bus.valid <= 1'b0;
    while (sb.pending_text.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input ntr_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Only called with the block idle: after reset or after drain().
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] radix_val,
                                input logic [CFG_DATA_W-1:0] limit_val);
    write_reg(REG_RADIX, radix_val);
    write_reg(REG_FRAC_LIMIT, limit_val);
    settings_used++;
  endtask

  // Mix of wide random values, small integer parts, short binary fractions that end early,
  // pure fractions and the range edges; about half are negated.
  function automatic logic [NUMBER_W-1:0] random_number();
    logic [63:0] v;
    logic [31:0] keep;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = {32'($urandom_range(0, 999)), $urandom};
      2: begin
        keep = 32'hFFFF_FFFF << $urandom_range(0, 31);
        v    = {$urandom, $urandom & keep};
      end
      3: v = {32'd0, $urandom};
      default: begin
        case ($urandom_range(0, 3))
          0: v = 64'h7FFF_FFFF_FFFF_FFFF;
          1: v = 64'h8000_0000_0000_0000;
          2: v = {32'($urandom_range(0, 40)), 32'd0};
          default: v = 64'd1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
    return v;
  endfunction

  initial begin
    int ph;
    int k;
    logic [CFG_DATA_W-1:0] r_val;
    logic [CFG_DATA_W-1:0] l_val;

    // Every input known from time zero; reset held high, then released at a falling edge.
    sb                      = new();
    rst                     = 1'b1;
    wr_en                   = 1'b0;
    wr_index                = REG_RADIX;
    wr_data                 = '0;
    number_bus.valid        = 1'b0;
    number_bus.data         = '0;
    send_gap_max            = 10;
    recv_gap_max            = 10;
    settings_used           = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings (radix 10, six fraction digits).
    send_number(64'h0000_0000_0000_0000);   // "0"
    send_number(64'h0000_0001_0000_0000);   // "1"
    send_number(64'hFFFF_FFFF_0000_0000);   // "-1"
    send_number(64'h0000_0000_0000_0001);   // tiny fraction trims away to "0"
    send_number(64'hFFFF_FFFF_FFFF_FFFF);   // negative with all-zero digits: "-0"
    send_number(64'h0000_0000_8000_0000);   // "0.5"
    send_number(64'hFFFF_FFFD_8000_0000);   // "-2.5"
    send_number(64'h7FFF_FFFF_FFFF_FFFF);   // largest positive
    send_number(64'h8000_0000_0000_0000);   // most negative, exact magnitude
    drain();

    // Binary with the full fraction length: longest texts.
    apply_settings(6'd2, 6'd29);
    send_number(64'h7FFF_FFFF_FFFF_FFFF);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'h0000_0000_5555_5555);
    send_number(64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // Radix 36; a limit of 31 clamps to 29.
    apply_settings(6'd36, 6'd31);
    send_number(64'h7FFF_FFFF_FFFF_FFFF);
    send_number(64'h0000_0023_FFFF_FFFF);
    send_number(64'h8000_0000_0000_0001);
    send_number(64'h0000_0000_0000_0001);
    drain();

    // Radix 0 acts as 2; limit zero means no point at all.
    apply_settings(6'd0, 6'd0);
    send_number(64'h0000_0005_8000_0000);
    send_number(64'hFFFF_FFFA_8000_0000);
    drain();

    // Radix 63 acts as 36; limit 30 clamps to 29.
    apply_settings(6'd63, 6'd30);
    send_number(64'h0000_0024_0000_0000);
    send_number(64'hFFFF_FFDB_C000_0000);
    drain();

    // Radix 1 acts as 2 with a single fraction digit; radix 37 acts as 36.
    apply_settings(6'd1, 6'd1);
    send_number(64'h0000_0003_C000_0000);
    drain();
    apply_settings(6'd37, 6'd5);
    send_number(64'h1234_5678_9ABC_DEF0);
    drain();

    // Random phases: each under its own settings, drained before the next write.
    // Some phases run one or both sides without gaps.
    for (ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin r_val = 6'd16; l_val = 6'd8;  end
        1: begin r_val = 6'd2;  l_val = 6'd29; end
        2: begin r_val = 6'd36; l_val = 6'd29; end
        3: begin r_val = 6'd10; l_val = 6'd0;  end
        default: begin
          r_val = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(2, 36));
          l_val = 6'($urandom_range(0, 31));
        end
      endcase
      apply_settings(r_val, l_val);
      send_gap_max = (ph % 3 == 1) ? 0 : 10;
      recv_gap_max = (ph % 4 == 2) ? 0 : 10;
      for (k = 0; k < 35; k++) send_number(random_number());
      drain();
    end

    // Let any stray beat show up before judging.
    repeat (400) @(posedge clk);

    $display("Converted %0d numbers into %0d characters under %0d register settings.",
             sb.numbers_seen, sb.chars_seen, settings_used);
    $display("Mismatches: %0d, characters still pending: %0d.",
             sb.errors, sb.pending_text.size());
    if (sb.errors == 0 && sb.pending_text.size() == 0) begin
      $display("number_to_radix_digit_string regression: pass");
    end else begin
      $display("number_to_radix_digit_string regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ntr_pkg.sv
hw/rtl/ntr_stream_if.sv
hw/rtl/ntr_ram.sv
hw/rtl/ntr_ctrl.sv
hw/rtl/ntr_datapath.sv
hw/rtl/number_to_radix_digit_string.sv
bench/tb_number_to_radix_digit_string.sv
